// File: hdl/fsc_pkg.sv
// Shared types and constants for the force sensor calibrate/scale block.
// No dependencies; imported by the lane, sequencer and top-level modules.
package fsc_pkg;

  localparam int CHANNELS_DEF   = 2;
  localparam int COUNT_BITS_DEF = 16;
  localparam int SAMPLE_BITS    = 10;
  localparam int PCT_BITS       = 8;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE    = 10'd1023;
  localparam logic [6:0]             PERCENT_SCALE = 7'd100;
  localparam logic [PCT_BITS-1:0]    PCT_MAX       = 8'd255;

  localparam logic FUNC_PASS  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  // Per-request commands broadcast to every lane.
  typedef struct packed {
    logic clear;
    logic add;
    logic start_pct;
    logic start_avg;
  } lane_ctrl_t;

  // Result flags held by the controller until the result is emitted.
  typedef struct packed {
    logic valid;
    logic calibrating;
    logic done;
  } res_flags_t;

endpackage

// File: hdl/fsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fsc_pkg only by convention; no package items are needed.
module fsc_div #(
  parameter int DW = 26,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [VW:0]   shifted;
  logic          ge;
  logic [VW:0]   diff;

  assign shifted = {rem, quo[DW-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign quotient = quo;

endmodule

// File: hdl/fsc_lane.sv
// One channel lane: running total, calibrated maximum and a serial divider
// that serves both the percentage and the calibration average.
// Depends on fsc_pkg and fsc_div.
module fsc_lane
  import fsc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_ctrl_t             ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [COUNT_BITS-1:0]  count,
  output logic [PCT_BITS-1:0]    pct,
  output logic                   done
);

  localparam int DW = COUNT_BITS + SAMPLE_BITS;
  localparam int VW = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;

  logic [DW-1:0]          total;
  logic [SAMPLE_BITS-1:0] max_val;
  logic                   avg_mode;

  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [VW-1:0]          div_divisor;
  logic [DW-1:0]          quotient;

  assign div_start    = ctrl.start_pct | ctrl.start_avg;
  assign div_dividend = ctrl.start_avg ? total
                                       : DW'(sample) * DW'(PERCENT_SCALE);
  assign div_divisor  = ctrl.start_avg ? VW'(count) : VW'(max_val);

  fsc_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      max_val  <= FULL_SCALE;
      avg_mode <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        total <= '0;
      end else if (ctrl.add) begin
        total <= total + DW'(sample);
      end
      if (div_start) begin
        avg_mode <= ctrl.start_avg;
      end
      // The average of samples that are at most full scale fits in 10 bits.
      if (done && avg_mode) begin
        max_val <= quotient[SAMPLE_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (max_val == '0 || quotient > DW'(PCT_MAX)) begin
      pct = PCT_MAX;
    end else begin
      pct = quotient[PCT_BITS-1:0];
    end
  end

endmodule

// File: hdl/fsc_ctrl.sv
// Sequencer of the block: calibration stage, timing, sample count and the
// commands sent to the lanes. Depends on fsc_pkg.
module fsc_ctrl
  import fsc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [31:0]           now_ms,
  input  logic [15:0]           timeout_ms,
  input  logic                  div_done,
  input  logic                  out_free,
  output lane_ctrl_t            lane_ctrl,
  output logic [COUNT_BITS-1:0] count,
  output res_flags_t            res,
  output logic                  load_out
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  ctrl_state_t           state, state_next;
  logic                  stage;
  logic [31:0]           start_time;
  logic [15:0]           cal_length;
  logic [COUNT_BITS-1:0] sample_count;

  logic                  accept;
  logic                  expired;
  logic [31:0]           elapsed;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign elapsed  = now_ms - start_time;
  assign expired  = elapsed > {16'b0, cal_length};
  assign count    = sample_count;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (lane_ctrl.start_pct || lane_ctrl.start_avg) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    lane_ctrl.clear     = accept && func == FUNC_START && !stage;
    lane_ctrl.add       = accept && func == FUNC_PASS && stage && !expired &&
                          sample_count != COUNT_MAX;
    lane_ctrl.start_pct = accept && func == FUNC_PASS && !stage;
    lane_ctrl.start_avg = accept && func == FUNC_PASS && stage && expired &&
                          sample_count != '0;
    load_out            = (state == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stage        <= 1'b0;
      start_time   <= '0;
      cal_length   <= '0;
      sample_count <= '0;
      res          <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        res.valid       <= func == FUNC_PASS && !stage;
        res.done        <= func == FUNC_PASS && stage && expired;
        res.calibrating <= (func == FUNC_START) || (stage && !expired);
        if (func == FUNC_START) begin
          if (!stage) begin
            stage        <= 1'b1;
            start_time   <= now_ms;
            cal_length   <= timeout_ms;
            sample_count <= '0;
          end
        end else if (stage) begin
          if (expired) begin
            stage <= 1'b0;
          end else if (sample_count != COUNT_MAX) begin
            sample_count <= sample_count + COUNT_BITS'(1);
          end
        end
      end
    end
  end

endmodule

// File: hdl/force_sensor_calibrate_scale.sv
// Top level of the force sensor calibrate/scale block: lanes, sequencer and
// the merging output register. Depends on fsc_pkg, fsc_ctrl and fsc_lane.
//
// Each request is one loop pass (two 10-bit force samples and a millisecond
// time) or a start-calibration command with a timeout, and it yields exactly
// one result. In idle, a loop pass reports each channel as
// floor(sample*100/max), saturated to 255; while calibrating, passes are
// summed per channel until the wrap-safe elapsed time exceeds the timeout,
// and then, if any were summed, each maximum becomes the channel average.
// One request is in work at a time. Start commands and passes that only
// accumulate go from acceptance to the emit state; a pass that computes
// percentages or ends a calibration with samples first waits in the divide
// state for the restoring divider in each lane, which retires one quotient
// bit per cycle over a COUNT_BITS + 10 bit dividend. The result waits in an
// output register, and a stalled result holds the block in its emit state,
// so the next request is not accepted until that register is free.
module force_sensor_calibrate_scale_core
  import fsc_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [31:0]            now_ms,
  input  logic [SAMPLE_BITS-1:0] sample0,
  input  logic [SAMPLE_BITS-1:0] sample1,
  input  logic [15:0]            timeout_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   percent_valid,
  output logic [PCT_BITS-1:0]    percent0,
  output logic [PCT_BITS-1:0]    percent1,
  output logic                   calibrating,
  output logic                   calib_done
);

  lane_ctrl_t            lane_ctrl;
  logic [COUNT_BITS-1:0] count;
  res_flags_t            res;
  logic                  load_out;
  logic                  out_free;

  logic [PCT_BITS-1:0]   lane_pct  [CHANNELS];
  logic [CHANNELS-1:0]   lane_done;
  logic [PCT_BITS-1:0]   pct0_sel;
  logic [PCT_BITS-1:0]   pct1_sel;

  // The output register is free when empty or when its result leaves now.
  assign out_free = !out_valid || !out_stall;

  fsc_ctrl #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .now_ms     (now_ms),
    .timeout_ms (timeout_ms),
    .div_done   (lane_done[0]),
    .out_free   (out_free),
    .lane_ctrl  (lane_ctrl),
    .count      (count),
    .res        (res),
    .load_out   (load_out)
  );

  // One lane per channel. Channels beyond the two sample inputs see zero,
  // so they still average to a defined maximum.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic [SAMPLE_BITS-1:0] lane_sample;
    if (i == 0) begin : g_s0
      assign lane_sample = sample0;
    end else if (i == 1) begin : g_s1
      assign lane_sample = sample1;
    end else begin : g_sz
      assign lane_sample = '0;
    end

    fsc_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl),
      .sample (lane_sample),
      .count  (count),
      .pct    (lane_pct[i]),
      .done   (lane_done[i])
    );
  end

  // Merge: the lanes' percentages only count for idle-stage passes, and a
  // channel that does not exist reports zero.
  assign pct0_sel = res.valid ? lane_pct[0] : '0;
  if (CHANNELS > 1) begin : g_pct1
    assign pct1_sel = res.valid ? lane_pct[1] : '0;
  end else begin : g_pct1_none
    assign pct1_sel = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      percent_valid <= res.valid;
      percent0      <= pct0_sel;
      percent1      <= pct1_sel;
      calibrating   <= res.calibrating;
      calib_done    <= res.done;
    end
  end

  // A finished calibration always leaves the block idle.
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    out_valid && calib_done |-> !calibrating)
    else $error("calibration finished but still calibrating");

  // Percentages are reported only from the idle stage.
  a_valid_excl : assert property (@(posedge clk) disable iff (rst)
    out_valid && percent_valid |-> !calib_done && !calibrating)
    else $error("percentages reported outside the idle stage");

  // A result without percentages carries zero percentages.
  a_pct_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !percent_valid |-> percent0 == '0 && percent1 == '0)
    else $error("percentages not cleared on a result without them");

  // Only one request is in work: the input stalls right after acceptance.
  a_one_inflight : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while one is in work");

endmodule
